// File: design/hcb_pkg.sv
// hcb_pkg: shared constants and types for the huffman code builder
// depends on nothing

package hcb_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
   localparam int NODE_BITS   = $clog2(NODE_COUNT + 1);
   localparam int SUM_BITS    = WEIGHT_BITS + $clog2(MAX_SYMBOLS) + 1;
   localparam int LEN_BITS    = $clog2(NODE_COUNT + 1);

   typedef logic [NODE_BITS-1:0] node_idx_type;
   typedef logic [SUM_BITS-1:0]  sum_type;

   // one node entry in the node memory
   typedef struct packed {
      sum_type      weight;
      node_idx_type parent;
      node_idx_type left;
      logic         used;
   } node_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_MARK,
      ST_MERGE,
      ST_WALK,
      ST_WALK_WAIT,
      ST_EMIT
   } state_type;

   // memory port request
   typedef struct packed {
      logic         we;
      node_idx_type waddr;
      node_type     wdata;
      node_idx_type raddr;
   } mem_req_type;

endpackage

// File: design/hcb_node_ram.sv
// hcb_node_ram: node store, one write and one registered read port
// depends on hcb_pkg

module hcb_node_ram (
   input  logic                clock,
   input  hcb_pkg::mem_req_type req,
   output hcb_pkg::node_type    rdata
);
   import hcb_pkg::*;

   node_type mem [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr[NODE_BITS-1:0]] <= req.wdata;
      end
      rdata <= mem[req.raddr];
   end

endmodule

// File: design/hcb_ctrl.sv
// hcb_ctrl: load, clear, merge scan and code walk sequencer
// depends on hcb_pkg, drives hcb_node_ram

module hcb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [5:0]                symbol_count,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [15:0]               in_weight,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [4:0]                out_index,
   output logic [30:0]               out_code,
   output logic [4:0]                out_len,
   output logic                      out_last,
   output hcb_pkg::mem_req_type      mreq,
   input  hcb_pkg::node_type         mrd
);
   import hcb_pkg::*;

   state_type    state_ff, state_in;
   node_idx_type n_ff, n_in;          // symbols in this set
   node_idx_type loaded_ff, loaded_in;
   node_idx_type k_ff, k_in;          // next node to create
   node_idx_type scan_ff, scan_in;    // address issued this cycle
   node_idx_type best_ff, best_in;
   sum_type      bestw_ff, bestw_in;
   logic         found_ff, found_in;
   logic         second_ff, second_in;
   node_idx_type a_ff, a_in;
   sum_type      aw_ff, aw_in;
   node_idx_type sym_ff, sym_in;
   node_idx_type cur_ff, cur_in;
   logic [30:0]  code_ff, code_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic         ovalid_ff, ovalid_in;
   logic [4:0]   oidx_ff, oidx_in;
   logic [30:0]  ocode_ff, ocode_in;
   logic [4:0]   olen_ff, olen_in;
   logic         olast_ff, olast_in;
   node_idx_type rd_addr_ff;          // address of data on mrd

   node_idx_type eff_n;
   logic         bit_val;

   always_comb begin
      eff_n = node_idx_type'(symbol_count);
      if (symbol_count == 6'd0) eff_n = node_idx_type'(1);
      if (symbol_count > 6'(MAX_SYMBOLS)) eff_n = node_idx_type'(MAX_SYMBOLS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         loaded_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         ovalid_ff <= ovalid_in;
      end
      n_ff <= n_in; k_ff <= k_in; scan_ff <= scan_in; best_ff <= best_in;
      bestw_ff <= bestw_in; found_ff <= found_in; second_ff <= second_in;
      a_ff <= a_in; aw_ff <= aw_in; sym_ff <= sym_in; cur_ff <= cur_in;
      code_ff <= code_in; len_ff <= len_in; oidx_ff <= oidx_in;
      ocode_ff <= ocode_in; olen_ff <= olen_in; olast_ff <= olast_in;
      rd_addr_ff <= mreq.raddr;
   end

   assign in_ready  = (state_ff == ST_LOAD);
   assign out_valid = ovalid_ff;
   assign out_index = oidx_ff;
   assign out_code  = ocode_ff;
   assign out_len   = olen_ff;
   assign out_last  = olast_ff;
   assign bit_val   = (mrd.left != cur_ff);

   always_comb begin
      state_in = state_ff; n_in = n_ff; loaded_in = loaded_ff; k_in = k_ff;
      scan_in = scan_ff; best_in = best_ff; bestw_in = bestw_ff;
      found_in = found_ff; second_in = second_ff; a_in = a_ff; aw_in = aw_ff;
      sym_in = sym_ff; cur_in = cur_ff; code_in = code_ff; len_in = len_ff;
      ovalid_in = ovalid_ff && !out_ready;
      oidx_in = oidx_ff; ocode_in = ocode_ff; olen_in = olen_ff;
      olast_in = olast_ff;
      mreq = '0;
      mreq.raddr = scan_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_valid) begin
               if (loaded_ff >= eff_n) loaded_in = node_idx_type'(1);
               else loaded_in = loaded_ff + node_idx_type'(1);
               mreq.we = 1'b1;
               mreq.waddr = (loaded_ff >= eff_n) ? '0 : loaded_ff;
               mreq.wdata.weight = sum_type'(in_weight[WEIGHT_BITS-1:0]);
               if (loaded_in == eff_n) begin
                  loaded_in = '0;
                  n_in = eff_n;
                  scan_in = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            // weights kept, link fields and used flag reset, one leaf per cycle
            mreq.raddr = scan_ff;
            scan_in = scan_ff + node_idx_type'(1);
            if (scan_ff != '0) begin
               mreq.we = 1'b1;
               mreq.waddr = scan_ff - node_idx_type'(1);
               mreq.wdata = mrd;
               mreq.wdata.parent = '0;
               mreq.wdata.left = '0;
               mreq.wdata.used = 1'b0;
            end
            if (scan_ff == n_ff) begin
               k_in = n_ff; second_in = 1'b0; found_in = 1'b0;
               scan_in = '0;
               state_in = (n_ff == node_idx_type'(1)) ? ST_WALK : ST_SCAN;
               sym_in = '0;
            end
         end
         ST_SCAN, ST_SCAN_LAST: begin
            // read issued last cycle for scan_ff-1
            if (state_ff == ST_SCAN_LAST || scan_ff != '0) begin
               if (!mrd.used && (!found_ff || mrd.weight < bestw_ff)) begin
                  found_in = 1'b1; best_in = rd_addr_ff; bestw_in = mrd.weight;
               end
            end
            if (state_ff == ST_SCAN_LAST) begin
               state_in = ST_MARK;
               mreq.raddr = best_in;
            end else begin
               scan_in = scan_ff + node_idx_type'(1);
               mreq.raddr = scan_ff;
               if (scan_ff == k_ff - node_idx_type'(1)) state_in = ST_SCAN_LAST;
            end
         end
         ST_MARK: begin
            // mrd holds best entry; set used and record parent
            mreq.we = 1'b1;
            mreq.waddr = best_ff;
            mreq.wdata = mrd;
            mreq.wdata.used = 1'b1;
            mreq.wdata.parent = k_ff;
            found_in = 1'b0;
            scan_in = '0;
            if (!second_ff) begin
               a_in = best_ff; aw_in = bestw_ff; second_in = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            mreq.we = 1'b1;
            mreq.waddr = k_ff;
            mreq.wdata.weight = aw_ff + bestw_ff;
            mreq.wdata.left = a_ff;
            mreq.wdata.parent = '0;
            mreq.wdata.used = 1'b0;
            second_in = 1'b0;
            k_in = k_ff + node_idx_type'(1);
            if (k_in == (n_ff << 1) - node_idx_type'(1)) begin
               sym_in = '0;
               state_in = ST_WALK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_WALK: begin
            // start a symbol: read its leaf
            cur_in = sym_ff; code_in = '0; len_in = '0;
            mreq.raddr = sym_ff;
            state_in = ST_WALK_WAIT;
         end
         ST_WALK_WAIT: begin
            // mrd = entry of cur; read its parent next
            if (rd_addr_ff == cur_ff) begin
               if (mrd.parent == '0 || n_ff == node_idx_type'(1)) begin
                  state_in = ST_EMIT;
               end else begin
                  mreq.raddr = mrd.parent;
               end
            end else begin
               // mrd = parent entry, cur is its child
               code_in = code_ff | (31'(bit_val) << len_ff[4:0]);
               len_in = len_ff + LEN_BITS'(1);
               cur_in = rd_addr_ff;
               if (mrd.parent == '0) state_in = ST_EMIT;
               else mreq.raddr = mrd.parent;
            end
         end
         ST_EMIT: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               oidx_in = sym_ff[4:0];
               ocode_in = code_ff;
               olen_in = len_ff[4:0];
               olast_in = (sym_ff + node_idx_type'(1) == n_ff);
               sym_in = sym_ff + node_idx_type'(1);
               state_in = olast_in ? ST_LOAD : ST_WALK;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

// File: design/huffman_code_builder_core.sv
// huffman_code_builder_core: top level, config register and wiring
// depends on hcb_pkg, hcb_ctrl, hcb_node_ram
//
// channel | direction | transfer
// req     | in        | one symbol weight
// rsp     | out       | one code per symbol, in symbol order
// csr     | in        | symbol count write
//
// a weight that does not finish a set is only written to the node memory
// the finishing weight starts a build: the leaves are cleared, then per merge
// two scans each followed by a mark step, then one merge step,
// all through the one node memory port
// then per symbol a walk from its leaf up to the root, and one emit step
// reset is synchronous; a stalled rsp holds the walk in its emit step

module huffman_code_builder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_symbol_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_symbol_index,
   output logic [30:0] rsp_code_bits,
   output logic [4:0]  rsp_code_length,
   output logic        rsp_last_code
);
   import hcb_pkg::*;

   logic [5:0]  symbol_count_ff;
   mem_req_type mreq;
   node_type    mrd;

   always_ff @(posedge clock) begin
      if (reset) symbol_count_ff <= 6'd32;
      else if (csr_write_enable) symbol_count_ff <= csr_write_data;
   end

   hcb_ctrl u_ctrl (
      .clock, .reset,
      .symbol_count(symbol_count_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_weight(req_symbol_weight),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_index(rsp_symbol_index), .out_code(rsp_code_bits),
      .out_len(rsp_code_length), .out_last(rsp_last_code),
      .mreq, .mrd
   );

   hcb_node_ram u_ram (.clock, .req(mreq), .rdata(mrd));

endmodule

// File: design/hcb_checker.sv
// hcb_checker: port-level assertions for huffman_code_builder_core
// depends on nothing; bound to the top level below

module hcb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_symbol_index,
   input logic        rsp_last_code,
   input logic [15:0] req_symbol_weight
);

   // offered weight holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_symbol_weight))
      else $error("offered weight changed");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_index))
      else $error("result dropped");

   // codes after a non-last transfer count up
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_code ##1 rsp_valid |->
      rsp_symbol_index == $past(rsp_symbol_index) + 5'd1) else $error("index order");

   // first code after reset quiet
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("output after reset");

endmodule

bind huffman_code_builder_core hcb_checker u_chk (.*);

// File: bench/tb.sv
// tb: self-checking bench for huffman_code_builder_core, predicts each code set on the fly
// depends on hcb_pkg and huffman_code_builder_core

module tb;
   import hcb_pkg::*;

   typedef struct {
      logic [4:0]  index;
      logic [30:0] bits;
      logic [4:0]  length;
      logic        last;
   } code_entry_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [5:0]  csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_symbol_weight;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_symbol_index;
   logic [30:0] rsp_code_bits;
   logic [4:0]  rsp_code_length;
   logic        rsp_last_code;

   huffman_code_builder_core u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol_weight (req_symbol_weight),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol_index  (rsp_symbol_index),
      .rsp_code_bits     (rsp_code_bits),
      .rsp_code_length   (rsp_code_length),
      .rsp_last_code     (rsp_last_code)
   );

   // predictor copy of the tree state
   logic [21:0] tree_weight [NODE_COUNT];
   int          tree_parent [NODE_COUNT];
   int          tree_left   [NODE_COUNT];
   bit          tree_used   [NODE_COUNT];
   int          weights_loaded;
   logic [5:0]  count_reg;

   logic [15:0] pending_weights [$];
   code_entry_type expected_codes [$];
   int          error_count;
   int          codes_checked;
   int          sets_built;
   longint      cycle_count;
   int          burst_left;
   int          gap_left;
   int          stall_mode;
   int          stall_timer;
   int          hold_left;
   bit          hold_wanted;
   bit          hold_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_lightest(int limit);
      int best;
      bit found;
      best = 0;
      found = 1'b0;
      for (int i = 0; i < limit; i++) begin
         if (!tree_used[i] && (!found || tree_weight[i] < tree_weight[best])) begin
            best = i;
            found = 1'b1;
         end
      end
      if (found) tree_used[best] = 1'b1;
      return best;
   endfunction

   task automatic predict_codes(input logic [15:0] weight);
      int n;
      int a;
      int b;
      int cur;
      int par;
      int len;
      logic [30:0] code;
      code_entry_type entry;
      n = (count_reg == 0) ? 1 : ((count_reg > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(count_reg));
      // a lowered count drops the partial set
      if (weights_loaded >= n) weights_loaded = 0;
      tree_weight[weights_loaded] = {6'd0, weight};
      weights_loaded++;
      if (weights_loaded < n) return;
      weights_loaded = 0;
      sets_built++;
      for (int i = 0; i < NODE_COUNT; i++) begin
         tree_parent[i] = 0;
         tree_left[i] = 0;
         tree_used[i] = 1'b0;
      end
      for (int k = n; k < 2 * n - 1; k++) begin
         a = pick_lightest(k);
         b = pick_lightest(k);
         tree_weight[k] = tree_weight[a] + tree_weight[b];
         tree_parent[a] = k;
         tree_parent[b] = k;
         tree_left[k] = a;
      end
      for (int i = 0; i < n; i++) begin
         code = '0;
         len = 0;
         cur = i;
         par = tree_parent[i];
         while (par != 0) begin
            if (len < 31) code[len] = (cur == tree_left[par]) ? 1'b0 : 1'b1;
            len++;
            cur = par;
            par = tree_parent[par];
         end
         entry.index = i[4:0];
         entry.bits = code;
         entry.length = len[4:0];
         entry.last = (i == n - 1);
         expected_codes.push_back(entry);
      end
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_symbol_weight <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) predict_codes(req_symbol_weight);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_weights.size() > 0) begin
               req_valid <= 1'b1;
               req_symbol_weight <= pending_weights.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern changes every so often, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 0;
         stall_timer <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_wanted && !hold_done && rsp_valid) begin
         hold_done <= 1'b1;
         hold_left <= 600;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 80);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // checker
   always @(posedge clock) begin
      code_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected code transfer index %0d", $time, rsp_symbol_index);
            error_count++;
         end else begin
            want = expected_codes.pop_front();
            codes_checked++;
            if (rsp_symbol_index !== want.index) begin
               $display("%0t: symbol_index expected %0d actual %0d",
                        $time, want.index, rsp_symbol_index);
               error_count++;
            end
            if (rsp_code_bits !== want.bits) begin
               $display("%0t: code_bits (symbol %0d) expected %h actual %h",
                        $time, want.index, want.bits, rsp_code_bits);
               error_count++;
            end
            if (rsp_code_length !== want.length) begin
               $display("%0t: code_length (symbol %0d) expected %0d actual %0d",
                        $time, want.index, want.length, rsp_code_length);
               error_count++;
            end
            if (rsp_last_code !== want.last) begin
               $display("%0t: last_code (symbol %0d) expected %0d actual %0d",
                        $time, want.index, want.last, rsp_last_code);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("timeout with %0d codes still expected", expected_codes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_count(input logic [5:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_reg = value;
   endtask

   task automatic drain();
      while (pending_weights.size() > 0 || req_valid || expected_codes.size() > 0)
         @(posedge clock);
      // a weight that finishes no set leaves no code to wait for
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] random_weight(int style);
      case (style)
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($urandom_range(0, 15));
         2: return 16'd7;
         3: return 16'($urandom_range(65520, 65535));
         default: return ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
      endcase
   endfunction

   task automatic queue_set(input int n, input int style);
      for (int i = 0; i < n; i++)
         pending_weights.push_back(random_weight(($urandom_range(0, 3) == 0) ?
                                                 $urandom_range(0, 4) : style));
   endtask

   initial begin
      int n;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      cycle_count = 0;
      error_count = 0;
      codes_checked = 0;
      sets_built = 0;
      weights_loaded = 0;
      count_reg = 6'd32;
      hold_wanted = 1'b0;
      for (int i = 0; i < NODE_COUNT; i++) tree_weight[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single symbol, zero count acting as one
      write_count(6'd1);
      pending_weights.push_back(16'h0000);
      pending_weights.push_back(16'hffff);
      drain();
      write_count(6'd0);
      pending_weights.push_back(16'h1234);
      drain();
      // two symbols: tie, extremes both ways
      write_count(6'd2);
      pending_weights.push_back(16'd5);
      pending_weights.push_back(16'd5);
      pending_weights.push_back(16'hffff);
      pending_weights.push_back(16'h0000);
      drain();
      // three and four with ties
      write_count(6'd3);
      pending_weights.push_back(16'hffff);
      pending_weights.push_back(16'hffff);
      pending_weights.push_back(16'hffff);
      drain();
      write_count(6'd4);
      pending_weights.push_back(16'd1);
      pending_weights.push_back(16'd1);
      pending_weights.push_back(16'd2);
      pending_weights.push_back(16'd2);
      drain();
      // count lowered mid-set drops the partial set
      write_count(6'd5);
      pending_weights.push_back(16'd9);
      pending_weights.push_back(16'd3);
      pending_weights.push_back(16'd8);
      drain();
      write_count(6'd2);
      pending_weights.push_back(16'd40);
      pending_weights.push_back(16'd2);
      drain();

      // count above the maximum, two sets with a long receiver hold-off
      write_count(6'd63);
      hold_wanted = 1'b1;
      queue_set(32, 0);
      queue_set(32, 1);
      drain();
      write_count(6'd32);
      queue_set(32, 4);
      drain();

      // random sets, mostly small counts
      for (int phase = 0; phase < 4; phase++) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         write_count(n[5:0]);
         repeat ($urandom_range(1, 2)) queue_set((n == 0) ? 1 : ((n > 32) ? 32 : n),
                                                  $urandom_range(0, 4));
         drain();
      end

      $display("covered %0d code sets and %0d checked codes, counts 0 to 63, tie and",
               sets_built, codes_checked);
      $display("extreme weights, a dropped partial set and a long output hold-off");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
design/hcb_pkg.sv
design/hcb_node_ram.sv
design/hcb_ctrl.sv
design/huffman_code_builder_core.sv
design/hcb_checker.sv
bench/tb.sv
